// File: hdl/hrsp_pkg.sv
`default_nettype none
package hrsp_pkg;

  localparam int SLOT_MAX_W = 8;
  localparam int CNT_MAX_W  = 9;
  localparam int HASH_W     = 32;

  localparam logic [HASH_W-1:0] MAGIC_WORD = 32'hEEFF_C000;
  localparam logic [HASH_W-1:0] END_WORD   = 32'hEFBE_ADDE;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_BYTE    = 2'd2;

  localparam logic [1:0] EV_DATA      = 2'd0;
  localparam logic [1:0] EV_END       = 2'd1;
  localparam logic [1:0] EV_BAD_MAGIC = 2'd2;
  localparam logic [1:0] EV_STORE_END = 2'd3;

  localparam logic [1:0] REG_START_OFFSET = 2'd0;
  localparam logic [1:0] REG_STORE_SIZE   = 2'd1;
  localparam logic [1:0] REG_KEY_COUNT    = 2'd2;

  typedef struct packed {
    logic                  start;
    logic [HASH_W-1:0]     hash;
    logic [CNT_MAX_W-1:0]  count;
  } srch_req_t;

  typedef struct packed {
    logic                  done;
    logic                  found;
    logic [SLOT_MAX_W-1:0] slot;
  } srch_rsp_t;

  typedef struct packed {
    logic                  we;
    logic [SLOT_MAX_W-1:0] slot;
    logic [HASH_W-1:0]     hash;
    logic                  enable;
  } key_wr_t;

endpackage
`default_nettype wire

// File: hdl/hrsp_ram.sv
`default_nettype none
module hrsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/hrsp_key_search.sv
`default_nettype none
module hrsp_key_search #(
  parameter int MAX_KEYS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire hrsp_pkg::key_wr_t   key_wr,
  input  wire hrsp_pkg::srch_req_t req,
  output hrsp_pkg::srch_rsp_t      rsp
);
  import hrsp_pkg::*;

  localparam int SLOT_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);

  logic [MAX_KEYS-1:0] en_r;
  logic                busy_r;
  logic                cmp_vld_r;
  logic [SLOT_W-1:0]   cmp_idx_r;
  logic [CNT_W-1:0]    issue_r;
  logic [CNT_W-1:0]    n_r;
  logic [HASH_W-1:0]   hash_r;

  logic [CNT_W-1:0]    n_nxt;
  logic [SLOT_W-1:0]   wr_idx;
  logic                wr_ok;
  logic [HASH_W-1:0]   rd_hash;
  logic                rd_en;
  logic                hit;
  logic                exhausted;

  assign wr_idx = SLOT_W'(key_wr.slot);
  assign wr_ok  = key_wr.we && ({1'b0, key_wr.slot} < CNT_MAX_W'(MAX_KEYS));

  // clamp the searched slot count to the table depth
  assign n_nxt = (req.count > CNT_MAX_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : CNT_W'(req.count);

  assign hit       = cmp_vld_r && en_r[cmp_idx_r] && (rd_hash == hash_r);
  assign exhausted = (issue_r >= n_r);
  assign rd_en     = busy_r && !hit && !exhausted;

  assign rsp.done  = busy_r && (hit || exhausted);
  assign rsp.found = hit;
  assign rsp.slot  = SLOT_MAX_W'(cmp_idx_r);

  hrsp_ram #(
    .WIDTH (HASH_W),
    .DEPTH (MAX_KEYS)
  ) u_hash_ram (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (wr_idx),
    .wdata (key_wr.hash),
    .re    (rd_en),
    .raddr (issue_r[SLOT_W-1:0]),
    .rdata (rd_hash)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r      <= '0;
      busy_r    <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      if (wr_ok) begin
        en_r[wr_idx] <= key_wr.enable;
      end
      if (req.start) begin
        busy_r    <= 1'b1;
        cmp_vld_r <= 1'b0;
      end else if (rsp.done) begin
        busy_r    <= 1'b0;
        cmp_vld_r <= 1'b0;
      end else if (rd_en) begin
        cmp_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      hash_r  <= req.hash;
      n_r     <= n_nxt;
      issue_r <= '0;
    end else if (rd_en) begin
      cmp_idx_r <= issue_r[SLOT_W-1:0];
      issue_r   <= issue_r + CNT_W'(1);
    end
  end

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    hit && busy_r |-> (CNT_W'(cmp_idx_r) < n_r))
    else $error("search hit on a slot beyond the searched count");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("search started while busy");

  a_busy_until_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !rsp.done && !req.start |=> busy_r)
    else $error("search dropped without completion");

endmodule
`default_nettype wire

// File: hdl/hashed_record_store_parser_top.sv
// Load, restart and ordinary store bytes are handled as they are taken; a result is registered and shows
// on the output in the cycle after its transaction.
// After the last byte of a nonzero-length record header, input is held while up to
// min(key_count, MAX_KEYS) key slots are searched, ending early on a match; one key slot per cycle.
// Input is not taken while a result waits unclaimed on the output.
// Synchronous active-low reset: parse done awaiting restart, all key slots disabled.
`default_nettype none
module hashed_record_store_parser_top #(
  parameter int MAX_KEYS     = 64,
  parameter int HEADER_BYTES = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // key_slot[5:0], key_hash[37:6], key_enabled[38], store_byte[46:39], zero[47]
  input  wire logic [47:0] in_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // match_slot[5:0], byte_offset[13:6], value_byte[21:14], byte_address[37:22], zero[39:38]
  output logic      [39:0] out_tdata,
  // event_res[1:0]
  output logic      [1:0]  out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import hrsp_pkg::*;

  typedef enum logic {ST_IDLE, ST_SEARCH} state_t;
  typedef enum logic [2:0] {PH_DONE, PH_MAGIC, PH_HEADER, PH_DATA, PH_SKIP} phase_t;

  logic [5:0]  in_key_slot;
  logic [31:0] in_key_hash;
  logic        in_key_enabled;
  logic [7:0]  in_store_byte;
  logic        in_fire;
  logic        out_fire;
  logic        cfg_wr;

  logic [15:0] start_r;
  logic [16:0] size_r;
  logic [6:0]  kcount_r;

  state_t      state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [5:0]  slot_r, slot_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [16:0] addr_r, addr_nxt;

  logic        out_valid_r;
  logic [1:0]  out_ev_r;
  logic [5:0]  out_slot_r;
  logic [7:0]  out_off_r;
  logic [7:0]  out_val_r;
  logic [15:0] out_addr_r;

  logic        emit;
  logic [1:0]  emit_ev;
  logic [5:0]  emit_slot;
  logic [7:0]  emit_off;
  logic [7:0]  emit_val;

  logic [3:0]  pos_inc;
  logic        hdr_last;
  logic [31:0] hash_upd;
  logic [7:0]  len_upd;
  logic [7:0]  cnt_inc;

  srch_req_t   srch_req;
  srch_rsp_t   srch_rsp;
  key_wr_t     key_wr;

  assign in_key_slot    = in_tdata[5:0];
  assign in_key_hash    = in_tdata[37:6];
  assign in_key_enabled = in_tdata[38];
  assign in_store_byte  = in_tdata[46:39];

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tdata  = {2'b00, out_addr_r, out_val_r, out_off_r, out_slot_r};

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_START_OFFSET: cfg_prdata = {16'd0, start_r};
      REG_STORE_SIZE:   cfg_prdata = {15'd0, size_r};
      REG_KEY_COUNT:    cfg_prdata = {25'd0, kcount_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= 16'd0;
      size_r   <= 17'd2048;
      kcount_r <= 7'd0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_START_OFFSET: start_r  <= cfg_pwdata[15:0];
        REG_STORE_SIZE:   size_r   <= cfg_pwdata[16:0];
        REG_KEY_COUNT:    kcount_r <= cfg_pwdata[6:0];
        default:          ;
      endcase
    end
  end

  // header byte collection
  assign pos_inc  = {1'b0, pos_r} + 4'd1;
  assign hdr_last = (pos_inc >= 4'(HEADER_BYTES));
  assign len_upd  = (pos_r == 3'd4) ? in_store_byte : len_r;
  assign cnt_inc  = cnt_r + 8'd1;

  always_comb begin
    hash_upd = hash_r;
    if (pos_r < 3'd4) begin
      hash_upd[{pos_r[1:0], 3'b000} +: 8] = in_store_byte;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    hash_nxt  = hash_r;
    len_nxt   = len_r;
    slot_nxt  = slot_r;
    cnt_nxt   = cnt_r;
    addr_nxt  = addr_r;
    emit      = 1'b0;
    emit_ev   = EV_DATA;
    emit_slot = 6'd0;
    emit_off  = 8'd0;
    emit_val  = 8'd0;
    srch_req  = '0;
    key_wr    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_tuser)
            OP_LOAD: begin
              key_wr.we     = 1'b1;
              key_wr.slot   = SLOT_MAX_W'(in_key_slot);
              key_wr.hash   = in_key_hash;
              key_wr.enable = in_key_enabled;
            end
            OP_RESTART: begin
              addr_nxt  = {1'b0, start_r};
              phase_nxt = PH_MAGIC;
              pos_nxt   = 3'd0;
              hash_nxt  = 32'd0;
              len_nxt   = 8'd0;
              slot_nxt  = 6'd0;
              cnt_nxt   = 8'd0;
            end
            OP_BYTE: begin
              if (phase_r == PH_HEADER && pos_r == 3'd0 && addr_r >= size_r) begin
                // store end: the byte is accepted but not parsed, and the address does not advance
                phase_nxt = PH_DONE;
                emit      = 1'b1;
                emit_ev   = EV_STORE_END;
              end else if (phase_r != PH_DONE) begin
                addr_nxt = addr_r + 17'd1;
                unique case (phase_r)
                  PH_MAGIC: begin
                    pos_nxt  = hdr_last ? 3'd0 : pos_inc[2:0];
                    hash_nxt = hash_upd;
                    len_nxt  = len_upd;
                    if (hdr_last) begin
                      if (hash_upd != MAGIC_WORD) begin
                        phase_nxt = PH_DONE;
                        emit      = 1'b1;
                        emit_ev   = EV_BAD_MAGIC;
                      end else begin
                        hash_nxt  = 32'd0;
                        phase_nxt = PH_HEADER;
                      end
                    end
                  end
                  PH_HEADER: begin
                    pos_nxt  = hdr_last ? 3'd0 : pos_inc[2:0];
                    hash_nxt = hash_upd;
                    len_nxt  = len_upd;
                    if (hdr_last) begin
                      if (hash_upd == END_WORD) begin
                        phase_nxt = PH_DONE;
                        emit      = 1'b1;
                        emit_ev   = EV_END;
                      end else begin
                        hash_nxt = 32'd0;
                        cnt_nxt  = 8'd0;
                        if (len_upd == 8'd0) begin
                          slot_nxt = 6'd0;
                        end else begin
                          srch_req.start = 1'b1;
                          srch_req.hash  = hash_upd;
                          srch_req.count = CNT_MAX_W'(kcount_r);
                          state_nxt      = ST_SEARCH;
                        end
                      end
                    end
                  end
                  PH_DATA, PH_SKIP: begin
                    cnt_nxt = cnt_inc;
                    if (cnt_inc >= len_r) begin
                      phase_nxt = PH_HEADER;
                    end
                    if (phase_r == PH_DATA) begin
                      emit      = 1'b1;
                      emit_ev   = EV_DATA;
                      emit_slot = slot_r;
                      emit_off  = cnt_r;
                      emit_val  = in_store_byte;
                    end
                  end
                  default: ;
                endcase
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (srch_rsp.done) begin
          slot_nxt  = srch_rsp.found ? srch_rsp.slot[5:0] : 6'd0;
          phase_nxt = srch_rsp.found ? PH_DATA : PH_SKIP;
          state_nxt = ST_IDLE;
        end
      end
      default: ;
    endcase
  end

  hrsp_key_search #(
    .MAX_KEYS (MAX_KEYS)
  ) u_key_search (
    .clk    (clk),
    .rst_n  (rst_n),
    .key_wr (key_wr),
    .req    (srch_req),
    .rsp    (srch_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_DONE;
      pos_r       <= 3'd0;
      hash_r      <= 32'd0;
      len_r       <= 8'd0;
      slot_r      <= 6'd0;
      cnt_r       <= 8'd0;
      addr_r      <= 17'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      hash_r  <= hash_nxt;
      len_r   <= len_nxt;
      slot_r  <= slot_nxt;
      cnt_r   <= cnt_nxt;
      addr_r  <= addr_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
        out_ev_r    <= emit_ev;
        out_slot_r  <= emit_slot;
        out_off_r   <= emit_off;
        out_val_r   <= emit_val;
        out_addr_r  <= addr_r[15:0];
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && (phase_r == PH_DATA || phase_r == PH_SKIP) |-> (cnt_r < len_r))
    else $error("record data count reached length without leaving the record");

  a_search_entered: assert property (@(posedge clk) disable iff (!rst_n)
    srch_req.start |=> (state_r == ST_SEARCH))
    else $error("search started but sequencer did not wait");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    srch_rsp.done |-> (state_r == ST_SEARCH))
    else $error("search completed while sequencer was not waiting");

endmodule
`default_nettype wire
